@@ src/dac_pkg.sv @@
`timescale 1ns / 1ps

package dac_pkg;

    // Event codes carried in the input tuser
    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_SNOOZE  = 3'd1,
        FUNC_DISMISS = 3'd2,
        FUNC_TRIGGER = 3'd3,
        FUNC_STOP    = 3'd4
    } func_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ALARM_ENABLE    = 3'd0,
        REG_DAY_MASK        = 3'd1,
        REG_ALARM_HOUR      = 3'd2,
        REG_ALARM_MINUTE    = 3'd3,
        REG_SNOOZE_MINUTES  = 3'd4,
        REG_TIMEOUT_MINUTES = 3'd5,
        REG_TONE_MODE       = 3'd6,
        REG_BEEP_LEVEL      = 3'd7
    } cfg_idx_t;

    // Tone modes
    localparam logic [1:0] TONE_STEADY = 2'd0;
    localparam logic [1:0] TONE_CHIME  = 2'd1;
    localparam logic [1:0] TONE_PULSE  = 2'd2;

    // Beep frequencies in Hz
    localparam logic [10:0] FREQ_STEADY  = 11'd1000;
    localparam logic [10:0] FREQ_CHIME_0 = 11'd784;
    localparam logic [10:0] FREQ_CHIME_1 = 11'd988;
    localparam logic [10:0] FREQ_CHIME_2 = 11'd1175;
    localparam logic [10:0] FREQ_PULSE_0 = 11'd880;
    localparam logic [10:0] FREQ_PULSE_1 = 11'd660;

    // Time conversions
    localparam int unsigned MS_PER_MIN   = 60000;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned MIN_PER_DAY  = 1440;

    // Minutes held as milliseconds, 255 minutes fit in 24 bits
    localparam int unsigned MIN_MS_W = 24;
    localparam int unsigned KEY_W    = 20;

    // Reset values of the configuration registers
    localparam logic                RST_ALARM_ENABLE = 1'b0;
    localparam logic [6:0]          RST_DAY_MASK     = 7'd127;
    localparam logic [4:0]          RST_ALARM_HOUR   = 5'd7;
    localparam logic [5:0]          RST_ALARM_MINUTE = 6'd0;
    localparam logic [MIN_MS_W-1:0] RST_SNOOZE_MS    = MIN_MS_W'(9 * MS_PER_MIN);
    localparam logic [MIN_MS_W-1:0] RST_TIMEOUT_MS   = '0;
    localparam logic [1:0]          RST_TONE_MODE    = TONE_STEADY;
    localparam logic [7:0]          RST_BEEP_LEVEL   = 8'd128;

    // Configuration as seen by the alarm core
    typedef struct packed {
        logic                alarm_enable;
        logic [6:0]          day_mask;
        logic [4:0]          alarm_hour;
        logic [5:0]          alarm_minute;
        logic [MIN_MS_W-1:0] snooze_ms;
        logic [MIN_MS_W-1:0] timeout_ms;
        logic [1:0]          tone_mode;
        logic [7:0]          beep_level;
    } cfg_t;

    // One input event
    typedef struct packed {
        func_t       func;
        logic [31:0] now_ms;
        logic [8:0]  year_day;
        logic [2:0]  week_day;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic        clock_synced;
    } event_t;

    // One result word
    typedef struct packed {
        logic        ringing;
        logic        beep_valid;
        logic [10:0] beep_freq;
        logic [7:0]  beep_ms;
        logic [7:0]  beep_volume;
    } result_t;

    // Frequency for the current tone step
    function automatic logic [10:0] pick_freq(input logic [1:0] mode, input logic [1:0] step);
        logic [10:0] freq;
        case (mode)
            TONE_CHIME: begin
                case (step)
                    2'd0:    freq = FREQ_CHIME_0;
                    2'd1:    freq = FREQ_CHIME_1;
                    2'd2:    freq = FREQ_CHIME_2;
                    default: freq = FREQ_CHIME_1;
                endcase
            end
            TONE_PULSE: freq = step[0] ? FREQ_PULSE_1 : FREQ_PULSE_0;
            default:    freq = FREQ_STEADY;
        endcase
        return freq;
    endfunction

endpackage

@@ src/dac_cfg.sv @@
`timescale 1ns / 1ps

module dac_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  dac_pkg::cfg_idx_t    wr_idx,
    input  logic [7:0]           wr_data,
    output dac_pkg::cfg_t        cfg
);
    import dac_pkg::*;

    cfg_t                cfg_reg;
    logic [MIN_MS_W-1:0] min_ms;

    // Minutes to milliseconds, done once at write time
    assign min_ms = MIN_MS_W'({16'd0, wr_data} * MIN_MS_W'(MS_PER_MIN));

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alarm_enable <= RST_ALARM_ENABLE;
            cfg_reg.day_mask     <= RST_DAY_MASK;
            cfg_reg.alarm_hour   <= RST_ALARM_HOUR;
            cfg_reg.alarm_minute <= RST_ALARM_MINUTE;
            cfg_reg.snooze_ms    <= RST_SNOOZE_MS;
            cfg_reg.timeout_ms   <= RST_TIMEOUT_MS;
            cfg_reg.tone_mode    <= RST_TONE_MODE;
            cfg_reg.beep_level   <= RST_BEEP_LEVEL;
        end else if (wr_en) begin
            case (wr_idx)
                REG_ALARM_ENABLE:    cfg_reg.alarm_enable <= wr_data[0];
                REG_DAY_MASK:        cfg_reg.day_mask     <= wr_data[6:0];
                REG_ALARM_HOUR:      cfg_reg.alarm_hour   <= wr_data[4:0];
                REG_ALARM_MINUTE:    cfg_reg.alarm_minute <= wr_data[5:0];
                REG_SNOOZE_MINUTES:  cfg_reg.snooze_ms    <= min_ms;
                REG_TIMEOUT_MINUTES: cfg_reg.timeout_ms   <= min_ms;
                REG_TONE_MODE:       cfg_reg.tone_mode    <= wr_data[1:0];
                REG_BEEP_LEVEL:      cfg_reg.beep_level   <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/dac_core.sv @@
`timescale 1ns / 1ps

module dac_core #(
    parameter int unsigned BEEP_PERIOD_MS = 260,
    parameter int unsigned BEEP_LENGTH_MS = 170
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dac_pkg::cfg_t    cfg,
    input  logic             ev_fire,
    input  dac_pkg::event_t  ev,
    output dac_pkg::result_t result,
    output logic             ringing
);
    import dac_pkg::*;

    // Alarm state
    logic              is_ringing_reg,      is_ringing_next;
    logic [31:0]       ring_start_ms_reg,   ring_start_ms_next;
    logic [31:0]       next_beep_ms_reg,    next_beep_ms_next;
    logic [1:0]        tone_index_reg,      tone_index_next;
    logic [31:0]       snooze_end_ms_reg,   snooze_end_ms_next;
    logic              dismissed_valid_reg, dismissed_valid_next;
    logic [8:0]        dismissed_day_reg,   dismissed_day_next;
    logic              fired_valid_reg,     fired_valid_next;
    logic [KEY_W-1:0]  fired_key_reg,       fired_key_next;

    logic [KEY_W-1:0]  minute_key;
    logic [7:0]        day_mask_ext;
    logic              schedule_ok;
    logic              beep_due;
    logic              timed_out;
    logic              beep;
    logic [10:0]       freq;

    // Tick decode
    assign minute_key = KEY_W'(KEY_W'(ev.year_day) * KEY_W'(MIN_PER_DAY))
                      + KEY_W'(KEY_W'(ev.hour_now) * KEY_W'(MIN_PER_HOUR))
                      + KEY_W'(ev.minute_now);
    assign day_mask_ext = {1'b0, cfg.day_mask};

    assign schedule_ok = cfg.alarm_enable
                      && !(snooze_end_ms_reg != '0 && ev.now_ms < snooze_end_ms_reg)
                      && ev.clock_synced
                      && !(dismissed_valid_reg && dismissed_day_reg == ev.year_day)
                      && day_mask_ext[ev.week_day]
                      && ev.hour_now == cfg.alarm_hour
                      && ev.minute_now == cfg.alarm_minute
                      && !(fired_valid_reg && fired_key_reg == minute_key);

    assign beep_due  = ev.now_ms >= next_beep_ms_reg;
    assign timed_out = cfg.timeout_ms != '0
                    && (ev.now_ms - ring_start_ms_reg) >= 32'(cfg.timeout_ms);
    assign freq      = pick_freq(cfg.tone_mode, tone_index_reg);

    // Next state and result for the current word
    always_comb begin
        is_ringing_next      = is_ringing_reg;
        ring_start_ms_next   = ring_start_ms_reg;
        next_beep_ms_next    = next_beep_ms_reg;
        tone_index_next      = tone_index_reg;
        snooze_end_ms_next   = snooze_end_ms_reg;
        dismissed_valid_next = dismissed_valid_reg;
        dismissed_day_next   = dismissed_day_reg;
        fired_valid_next     = fired_valid_reg;
        fired_key_next       = fired_key_reg;
        beep                 = 1'b0;

        case (ev.func)
            FUNC_TICK: begin
                if (is_ringing_reg) begin
                    if (beep_due) begin
                        beep              = 1'b1;
                        tone_index_next   = tone_index_reg + 2'd1;
                        next_beep_ms_next = ev.now_ms + 32'(BEEP_PERIOD_MS);
                    end
                    // timeout acts as a dismiss, after the beep check
                    if (timed_out) begin
                        is_ringing_next      = 1'b0;
                        ring_start_ms_next   = '0;
                        next_beep_ms_next    = '0;
                        dismissed_valid_next = 1'b1;
                        dismissed_day_next   = ev.year_day;
                        snooze_end_ms_next   = '0;
                    end
                end else if (schedule_ok) begin
                    fired_valid_next   = 1'b1;
                    fired_key_next     = minute_key;
                    is_ringing_next    = 1'b1;
                    ring_start_ms_next = ev.now_ms;
                    next_beep_ms_next  = '0;
                    tone_index_next    = '0;
                end
            end
            FUNC_SNOOZE: begin
                if (is_ringing_reg) begin
                    is_ringing_next    = 1'b0;
                    ring_start_ms_next = '0;
                    next_beep_ms_next  = '0;
                    snooze_end_ms_next = ev.now_ms + 32'(cfg.snooze_ms);
                end
            end
            FUNC_DISMISS: begin
                if (is_ringing_reg) begin
                    is_ringing_next      = 1'b0;
                    ring_start_ms_next   = '0;
                    next_beep_ms_next    = '0;
                    dismissed_valid_next = 1'b1;
                    dismissed_day_next   = ev.year_day;
                    snooze_end_ms_next   = '0;
                end
            end
            FUNC_TRIGGER: begin
                snooze_end_ms_next   = '0;
                dismissed_valid_next = 1'b0;
                is_ringing_next      = 1'b1;
                ring_start_ms_next   = ev.now_ms;
                next_beep_ms_next    = '0;
                tone_index_next      = '0;
            end
            FUNC_STOP: begin
                is_ringing_next    = 1'b0;
                ring_start_ms_next = '0;
                next_beep_ms_next  = '0;
            end
            default: ;
        endcase

        result.ringing     = is_ringing_next;
        result.beep_valid  = beep;
        result.beep_freq   = beep ? freq : '0;
        result.beep_ms     = beep ? 8'(BEEP_LENGTH_MS) : '0;
        result.beep_volume = beep ? cfg.beep_level : '0;
    end

    // State registers, updated once per word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_ringing_reg      <= 1'b0;
            ring_start_ms_reg   <= '0;
            next_beep_ms_reg    <= '0;
            tone_index_reg      <= '0;
            snooze_end_ms_reg   <= '0;
            dismissed_valid_reg <= 1'b0;
            dismissed_day_reg   <= '0;
            fired_valid_reg     <= 1'b0;
            fired_key_reg       <= '0;
        end else if (ev_fire) begin
            is_ringing_reg      <= is_ringing_next;
            ring_start_ms_reg   <= ring_start_ms_next;
            next_beep_ms_reg    <= next_beep_ms_next;
            tone_index_reg      <= tone_index_next;
            snooze_end_ms_reg   <= snooze_end_ms_next;
            dismissed_valid_reg <= dismissed_valid_next;
            dismissed_day_reg   <= dismissed_day_next;
            fired_valid_reg     <= fired_valid_next;
            fired_key_reg       <= fired_key_next;
        end
    end

    assign ringing = is_ringing_reg;

endmodule

@@ src/daily_alarm_controller.sv @@
`timescale 1ns / 1ps
// Daily alarm controller.
// Input stream: one event word per transfer. tuser carries the event code
// (tick, snooze, dismiss, trigger, stop), tdata the millisecond count and the
// local calendar time. Output stream: one result word per event, with the
// ringing flag and the beep descriptor (valid, frequency, length, volume).
// Configuration: a separate write channel, one register per write, always
// ready; write it only while no event is in flight.
// Path: an accepted word is held in the input register, its result in the result
// register. Throughput: one event per cycle unless the output stalls; the whole
// alarm decision is one level of compares and adds between the two registers.
// Stall: while the result register is held, the input register takes one
// more word; once both are full, s_axis_tready drops until m_axis_tready rises.
// Reset (aresetn low, synchronous): alarm idle, no snooze, no dismissed day,
// no minute fired, registers at their documented defaults, both streams empty.
module daily_alarm_controller #(
    parameter int unsigned BEEP_PERIOD_MS = 260,
    parameter int unsigned BEEP_LENGTH_MS = 170
) (
    input  logic        aclk,
    input  logic        aresetn,
    // event input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // now_ms[31:0], year_day[40:32], week_day[43:41], hour_now[48:44],
    // minute_now[54:49], clock_synced[55]
    input  logic [55:0] s_axis_tdata,
    // func[2:0]
    input  logic [2:0]  s_axis_tuser,
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ringing[0], beep_valid[1], beep_freq[12:2], beep_ms[20:13],
    // beep_volume[28:21], zero[31:29]
    output logic [31:0] m_axis_tdata,
    // configuration writes
    input  logic        cfg_wvalid,
    output logic        cfg_wready,
    input  logic [2:0]  cfg_waddr,
    input  logic [7:0]  cfg_wdata
);
    import dac_pkg::*;

    logic    in_valid_reg;
    event_t  in_event_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    logic    advance;
    logic    s_accept;
    logic    ev_fire;
    cfg_t    cfg;
    result_t result;
    logic    ringing;

    // Handshake
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign ev_fire       = in_valid_reg && advance;
    assign cfg_wready    = 1'b1;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (ev_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_event_reg.func         <= func_t'(s_axis_tuser);
            in_event_reg.now_ms       <= s_axis_tdata[31:0];
            in_event_reg.year_day     <= s_axis_tdata[40:32];
            in_event_reg.week_day     <= s_axis_tdata[43:41];
            in_event_reg.hour_now     <= s_axis_tdata[48:44];
            in_event_reg.minute_now   <= s_axis_tdata[54:49];
            in_event_reg.clock_synced <= s_axis_tdata[55];
        end
    end

    // Configuration registers
    dac_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wvalid && cfg_wready),
        .wr_idx  (cfg_idx_t'(cfg_waddr)),
        .wr_data (cfg_wdata),
        .cfg     (cfg)
    );

    // Alarm state and event decode
    dac_core #(
        .BEEP_PERIOD_MS (BEEP_PERIOD_MS),
        .BEEP_LENGTH_MS (BEEP_LENGTH_MS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .ev_fire (ev_fire),
        .ev      (in_event_reg),
        .result  (result),
        .ringing (ringing)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_fire) begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0,
                            out_result_reg.beep_volume,
                            out_result_reg.beep_ms,
                            out_result_reg.beep_freq,
                            out_result_reg.beep_valid,
                            out_result_reg.ringing};

`ifndef SYNTHESIS
    // A trigger always leaves the alarm ringing
    a_trigger_rings: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_fire && in_event_reg.func == FUNC_TRIGGER |=> ringing)
        else $error("trigger did not start the alarm");

    // A stop always leaves the alarm idle
    a_stop_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_fire && in_event_reg.func == FUNC_STOP |=> !ringing)
        else $error("stop did not end the alarm");

    // The reported ringing flag matches the state left by that word
    a_ringing_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_fire |=> out_valid_reg && out_result_reg.ringing == ringing)
        else $error("result ringing flag disagrees with alarm state");

    // No input word is taken while both registers are held
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipeline is full");
`endif

endmodule

@@ tb/daily_alarm_controller_test.sv @@
`timescale 1ns / 1ps

module daily_alarm_controller_test;
    import dac_pkg::*;

    localparam logic [1:0] TONE_SPARE = 2'd3;

    // Mirror of the alarm: register copies, alarm state, and the results still owed
    class alarm_mirror;
        localparam int unsigned BEEP_GAP_MS = 260;
        localparam int unsigned BEEP_LEN_MS = 170;

        bit        enable;
        bit [6:0]  day_mask;
        bit [4:0]  hour_set;
        bit [5:0]  minute_set;
        bit [7:0]  snooze_min;
        bit [7:0]  timeout_min;
        bit [1:0]  tone_mode;
        bit [7:0]  level;

        bit        ringing;
        bit [31:0] ring_start_ms;
        bit [31:0] next_beep_ms;
        bit [31:0] snooze_end_ms;
        bit [1:0]  tone_step;
        bit        dismissed_valid;
        bit [8:0]  dismissed_day;
        bit        fired_valid;
        bit [19:0] fired_key;

        result_t   owed[$];

        function void clear();
            enable        = RST_ALARM_ENABLE;
            day_mask      = RST_DAY_MASK;
            hour_set      = RST_ALARM_HOUR;
            minute_set    = RST_ALARM_MINUTE;
            snooze_min    = 8'(RST_SNOOZE_MS / MS_PER_MIN);
            timeout_min   = 8'(RST_TIMEOUT_MS / MS_PER_MIN);
            tone_mode     = RST_TONE_MODE;
            level         = RST_BEEP_LEVEL;
            ringing       = 1'b0;
            ring_start_ms = '0;
            next_beep_ms  = '0;
            snooze_end_ms = '0;
            tone_step     = '0;
            dismissed_valid = 1'b0;
            dismissed_day = '0;
            fired_valid   = 1'b0;
            fired_key     = '0;
            owed.delete();
        endfunction

        function void set_reg(cfg_idx_t idx, bit [7:0] value);
            case (idx)
                REG_ALARM_ENABLE:    enable      = value[0];
                REG_DAY_MASK:        day_mask    = value[6:0];
                REG_ALARM_HOUR:      hour_set    = value[4:0];
                REG_ALARM_MINUTE:    minute_set  = value[5:0];
                REG_SNOOZE_MINUTES:  snooze_min  = value;
                REG_TIMEOUT_MINUTES: timeout_min = value;
                REG_TONE_MODE:       tone_mode   = value[1:0];
                REG_BEEP_LEVEL:      level       = value;
                default: ;
            endcase
        endfunction

        function void ring_begin(bit [31:0] now);
            ringing       = 1'b1;
            ring_start_ms = now;
            next_beep_ms  = '0;
            tone_step     = '0;
        endfunction

        // tone step survives a stop
        function void ring_end();
            ringing       = 1'b0;
            ring_start_ms = '0;
            next_beep_ms  = '0;
        endfunction

        function void dismiss(bit [8:0] day);
            ring_end();
            dismissed_valid = 1'b1;
            dismissed_day   = day;
            snooze_end_ms   = '0;
        endfunction

        // Apply one accepted event word and queue the result it owes
        function void take_event(event_t ev);
            result_t   res;
            bit [7:0]  mask8;
            bit [19:0] key;
            bit [31:0] elapsed;
            bit [31:0] limit_ms;
            bit        arm;
            res = '0;
            case (ev.func)
                FUNC_TICK: begin
                    if (ringing) begin
                        if (ev.now_ms >= next_beep_ms) begin
                            res.beep_valid  = 1'b1;
                            res.beep_ms     = 8'(BEEP_LEN_MS);
                            res.beep_volume = level;
                            if (tone_mode == TONE_PULSE)
                                res.beep_freq = tone_step[0] ? FREQ_PULSE_1 : FREQ_PULSE_0;
                            else if (tone_mode != TONE_CHIME)
                                res.beep_freq = FREQ_STEADY;
                            else if (tone_step == 2'd0)
                                res.beep_freq = FREQ_CHIME_0;
                            else
                                res.beep_freq = (tone_step == 2'd2) ? FREQ_CHIME_2 : FREQ_CHIME_1;
                            tone_step++;
                            next_beep_ms = ev.now_ms + BEEP_GAP_MS;
                        end
                        // timeout is checked after the beep, on wrapping time
                        elapsed  = ev.now_ms - ring_start_ms;
                        limit_ms = timeout_min * MS_PER_MIN;
                        if (timeout_min != 0 && elapsed >= limit_ms)
                            dismiss(ev.year_day);
                    end else begin
                        mask8 = {1'b0, day_mask};
                        key = 20'(ev.year_day * MIN_PER_DAY + ev.hour_now * MIN_PER_HOUR
                                  + ev.minute_now);
                        arm = enable && ev.clock_synced
                            && !(snooze_end_ms != 0 && ev.now_ms < snooze_end_ms)
                            && !(dismissed_valid && dismissed_day == ev.year_day)
                            && mask8[ev.week_day]
                            && ev.hour_now == hour_set && ev.minute_now == minute_set
                            && !(fired_valid && fired_key == key);
                        if (arm) begin
                            fired_valid = 1'b1;
                            fired_key   = key;
                            ring_begin(ev.now_ms);
                        end
                    end
                end
                FUNC_SNOOZE: begin
                    if (ringing) begin
                        ring_end();
                        snooze_end_ms = ev.now_ms + snooze_min * MS_PER_MIN;
                    end
                end
                FUNC_DISMISS: begin
                    if (ringing)
                        dismiss(ev.year_day);
                end
                FUNC_TRIGGER: begin
                    snooze_end_ms   = '0;
                    dismissed_valid = 1'b0;
                    ring_begin(ev.now_ms);
                end
                FUNC_STOP: ring_end();
                default: ;
            endcase
            res.ringing = ringing;
            owed.push_back(res);
        endfunction

        // Compare one result word with the oldest owed result; empty string when it matches
        function string match_result(logic [31:0] word);
            result_t want;
            string   why;
            if (owed.size() == 0)
                return $sformatf(" result %h with no event waiting", word);
            want = owed.pop_front();
            why = "";
            if (word[0] !== want.ringing)
                why = {why, $sformatf(" ringing %b want %b", word[0], want.ringing)};
            if (word[1] !== want.beep_valid)
                why = {why, $sformatf(" beep_valid %b want %b", word[1], want.beep_valid)};
            if (word[12:2] !== want.beep_freq)
                why = {why, $sformatf(" beep_freq %0d want %0d", word[12:2], want.beep_freq)};
            if (word[20:13] !== want.beep_ms)
                why = {why, $sformatf(" beep_ms %0d want %0d", word[20:13], want.beep_ms)};
            if (word[28:21] !== want.beep_volume)
                why = {why, $sformatf(" beep_volume %0d want %0d", word[28:21],
                                      want.beep_volume)};
            return why;
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;  // now_ms, year_day, week_day, hour_now, minute_now, synced
    logic [2:0]  s_axis_tuser  = '0;  // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // ringing, beep_valid, beep_freq, beep_ms, beep_volume
    logic        cfg_wvalid    = 1'b0;
    logic        cfg_wready;
    logic [2:0]  cfg_waddr     = '0;
    logic [7:0]  cfg_wdata     = '0;

    alarm_mirror mirror = new();

    int unsigned mismatches     = 0;
    int unsigned feed_gap_pct   = 0;
    int unsigned sink_stall_pct = 0;
    bit [7:0]    reg_plan [8];

    // Stimulus time line
    bit [31:0]   clock_ms = '0;
    bit [8:0]    cur_day  = '0;
    bit [2:0]    cur_wday = '0;

    daily_alarm_controller dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wvalid    (cfg_wvalid),
        .cfg_wready    (cfg_wready),
        .cfg_waddr     (cfg_waddr),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at %0t:%s", $time, what);
    endtask

    function automatic event_t make_event(func_t f, bit [31:0] now, bit [8:0] yday,
                                          bit [2:0] wday, bit [4:0] hr, bit [5:0] mn,
                                          bit synced);
        event_t ev;
        ev.func         = f;
        ev.now_ms       = now;
        ev.year_day     = yday;
        ev.week_day     = wday;
        ev.hour_now     = hr;
        ev.minute_now   = mn;
        ev.clock_synced = synced;
        return ev;
    endfunction

    // Offer one event word, with random gaps ahead of it
    task automatic send_event(event_t ev);
        while ($urandom_range(0, 99) < feed_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev.func;
        s_axis_tdata  <= {ev.clock_synced, ev.minute_now, ev.hour_now, ev.week_day,
                          ev.year_day, ev.now_ms};
        do @(posedge aclk); while (!s_axis_tready);
        mirror.take_event(ev);
    endtask

    // Write all eight registers from reg_plan
    task automatic program_regs();
        for (int i = 0; i < 8; i++) begin
            cfg_wvalid <= 1'b1;
            cfg_waddr  <= cfg_idx_t'(i);
            cfg_wdata  <= reg_plan[i];
            do @(posedge aclk); while (!cfg_wready);
            mirror.set_reg(cfg_idx_t'(i), reg_plan[i]);
        end
        cfg_wvalid <= 1'b0;
    endtask

    // Stop feeding, wait out every owed result, then let the clock run on idle
    task automatic drain();
        int unsigned spin;
        spin = 0;
        s_axis_tvalid <= 1'b0;
        while (mirror.owed.size() != 0 && spin < 5000) begin
            @(posedge aclk);
            spin++;
        end
        if (mirror.owed.size() != 0) begin
            report_mismatch($sformatf(" %0d results never arrived", mirror.owed.size()));
            mirror.owed.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    // Result side: check each accepted word, stall at random
    always @(posedge aclk) begin : result_sink
        string why;
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            why = mirror.match_result(m_axis_tdata);
            if (why != "")
                report_mismatch(why);
        end
        m_axis_tready <= aresetn && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    initial begin : main
        event_t      ev;
        int unsigned r;
        mirror.clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass: chime tone, one-minute snooze and timeout
        feed_gap_pct   = 16;
        sink_stall_pct = 63;
        reg_plan = '{8'd1, 8'd127, 8'd7, 8'd0, 8'd1, 8'd1, 8'(TONE_CHIME), 8'd255};
        program_regs();
        // scheduled fire, first beep at once, then every period through the chime
        send_event(make_event(FUNC_TICK, 32'd1000, 9'd0, 3'd0, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_TICK, 32'd1000, 9'd0, 3'd0, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_TICK, 32'd1259, 9'd0, 3'd0, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_TICK, 32'd1260, 9'd0, 3'd0, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_TICK, 32'd1520, 9'd0, 3'd0, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_TICK, 32'd1780, 9'd0, 3'd0, 5'd7, 6'd0, 1'b1));
        // snooze holds off the next day's fire
        send_event(make_event(FUNC_SNOOZE, 32'd2000, 9'd0, 3'd0, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_TICK, 32'd3000, 9'd1, 3'd1, 5'd7, 6'd0, 1'b1));
        // trigger near wrap: next beep wraps and is due at once; timeout on wrapped time
        send_event(make_event(FUNC_TRIGGER, 32'hFFFF_FF00, 9'd5, 3'd2, 5'd3, 6'd9, 1'b1));
        send_event(make_event(FUNC_TICK, 32'hFFFF_FFF0, 9'd5, 3'd2, 5'd3, 6'd9, 1'b1));
        send_event(make_event(FUNC_TICK, 32'hFFFF_FFF8, 9'd5, 3'd2, 5'd3, 6'd9, 1'b1));
        send_event(make_event(FUNC_TICK, 32'hFFFF_FF00 + MS_PER_MIN, 9'd5, 3'd2, 5'd3,
                              6'd10, 1'b1));
        // dismissed day blocks the fire
        send_event(make_event(FUNC_TICK, 32'h0002_0000, 9'd5, 3'd2, 5'd7, 6'd0, 1'b1));
        // commands while idle, unused codes
        send_event(make_event(FUNC_DISMISS, 32'h0002_0100, 9'd6, 3'd3, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_SNOOZE, 32'h0002_0200, 9'd6, 3'd3, 5'd7, 6'd0, 1'b1));
        send_event(make_event(func_t'(3'(FUNC_STOP) + 3'd1), 32'h0002_0300, 9'd6, 3'd3,
                              5'd7, 6'd0, 1'b1));
        send_event(make_event(func_t'(3'(FUNC_STOP) + 3'd3), 32'h0002_0400, 9'd6, 3'd3,
                              5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_STOP, 32'h0002_0500, 9'd6, 3'd3, 5'd7, 6'd0, 1'b1));
        // unsynced clock, weekday seven, then a real fire; no refire in the same minute
        send_event(make_event(FUNC_TICK, 32'h0003_0000, 9'd9, 3'd3, 5'd7, 6'd0, 1'b0));
        send_event(make_event(FUNC_TICK, 32'h0003_0000, 9'd9, 3'd7, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_TICK, 32'h0003_0000, 9'd9, 3'd3, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_STOP, 32'h0003_0010, 9'd9, 3'd3, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_TICK, 32'h0003_0020, 9'd9, 3'd3, 5'd7, 6'd0, 1'b1));
        // snooze whose end sums to zero counts as no snooze
        send_event(make_event(FUNC_TRIGGER, 32'hFFFF_FFFF - (MS_PER_MIN - 1), 9'd9, 3'd3,
                              5'd8, 6'd1, 1'b1));
        send_event(make_event(FUNC_SNOOZE, 32'hFFFF_FFFF - (MS_PER_MIN - 1), 9'd9, 3'd3,
                              5'd8, 6'd1, 1'b1));
        send_event(make_event(FUNC_TICK, 32'd100, 9'd10, 3'd4, 5'd7, 6'd0, 1'b1));
        send_event(make_event(FUNC_DISMISS, 32'd200, 9'd10, 3'd4, 5'd7, 6'd0, 1'b1));
        // all fields at their top values
        send_event(make_event(FUNC_TICK, 32'hFFFF_FFFF, 9'h1FF, 3'd7, 5'h1F, 6'h3F, 1'b1));

        // Random phases: each with its own register setting; pacing changes every two phases
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: reg_plan = '{8'd1, 8'd127, 8'($urandom_range(0, 23)),
                                8'($urandom_range(0, 59)), 8'd1, 8'd1, 8'(TONE_STEADY), 8'd255};
                1: reg_plan = '{8'd1, 8'($urandom_range(1, 127)), 8'd23, 8'd59, 8'd0, 8'd0,
                                8'(TONE_CHIME), 8'd0};
                2: reg_plan = '{8'd1, 8'($urandom_range(1, 127)), 8'd0, 8'd0, 8'd255, 8'd2,
                                8'(TONE_PULSE), 8'($urandom)};
                3: reg_plan = '{8'd0, 8'd0, 8'($urandom_range(0, 23)),
                                8'($urandom_range(0, 59)), 8'($urandom), 8'd255,
                                8'(TONE_SPARE), 8'($urandom)};
                default: begin
                    foreach (reg_plan[i])
                        reg_plan[i] = 8'($urandom);
                    if (phase == 4)
                        reg_plan[REG_ALARM_ENABLE][0] = 1'b1;
                end
            endcase
            program_regs();
            feed_gap_pct   = (phase < 2) ? 16 : (phase < 4) ? 63 : 0;
            sink_stall_pct = (phase < 2) ? 63 : (phase < 4) ? 16 : 0;

            repeat (160) begin
                // mostly ticks, with commands mixed in and a few unused codes
                r = $urandom_range(0, 99);
                if (r < 66)      ev.func = FUNC_TICK;
                else if (r < 74) ev.func = FUNC_SNOOZE;
                else if (r < 81) ev.func = FUNC_DISMISS;
                else if (r < 87) ev.func = FUNC_TRIGGER;
                else if (r < 94) ev.func = FUNC_STOP;
                else             ev.func = func_t'(3'(FUNC_STOP) + 3'($urandom_range(1, 3)));

                // time moves mostly by beep-sized steps, sometimes minutes or anywhere
                r = $urandom_range(0, 99);
                if (r < 60)      clock_ms += $urandom_range(0, 300);
                else if (r < 80) clock_ms += $urandom_range(250, 270);
                else if (r < 90) clock_ms += $urandom_range(1, 4) * MS_PER_MIN
                                             + $urandom_range(0, 1000);
                else if (r < 96) clock_ms = $urandom;
                else             clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                ev.now_ms = clock_ms;

                // calendar mostly sits at the alarm time, day moves now and then
                if ($urandom_range(0, 99) < 8) begin
                    cur_day  = 9'($urandom_range(0, 365));
                    cur_wday = 3'($urandom_range(0, 6));
                end
                ev.year_day   = cur_day;
                ev.week_day   = cur_wday;
                ev.hour_now   = mirror.hour_set;
                ev.minute_now = mirror.minute_set;
                r = $urandom_range(0, 99);
                if (r >= 90) begin
                    ev.year_day   = 9'($urandom);
                    ev.week_day   = 3'($urandom);
                    ev.hour_now   = 5'($urandom);
                    ev.minute_now = 6'($urandom);
                end else if (r >= 70) begin
                    ev.hour_now   = 5'($urandom_range(0, 23));
                    ev.minute_now = 6'($urandom_range(0, 59));
                end
                ev.clock_synced = ($urandom_range(0, 9) != 0);
                send_event(ev);
            end
        end

        drain();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
